// ===== rtl/plr_pkg.sv =====
// Package: shared codes, widths and state types of the positional list engine.
`default_nettype none
package plr_pkg;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 11;
  localparam int ITEM_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_INS_POS  = 3'd2,
    FN_REM_HEAD = 3'd3,
    FN_REM_TAIL = 3'd4,
    FN_REM_POS  = 3'd5,
    FN_READ     = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN,
    S_WAIT,
    S_PUT,
    S_RESP
  } state_t;

  // what to do with the RAM read data in the cycle after a read
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_CAPTURE,
    TAG_MOVE
  } tag_t;

endpackage
`default_nettype wire

// ===== rtl/plr_if.sv =====
// Interfaces: command and response channels of the positional list engine.
`default_nettype none
interface plr_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [plr_pkg::FUNC_W-1:0]    func;
  logic [plr_pkg::POS_W-1:0]     position;
  logic [plr_pkg::ITEM_W-1:0]    item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface plr_rsp_if;
  logic                          valid;
  logic                          ready;
  plr_pkg::status_t              status;
  logic                          value_valid;
  logic [plr_pkg::ITEM_W-1:0]    out_value;
  logic [plr_pkg::CNT_W-1:0]     entry_count;

  modport source (output valid, status, value_valid, out_value, entry_count, input ready);
  modport sink   (input valid, status, value_valid, out_value, entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/plr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
`default_nettype none
module plr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Top level: ordered handle list in a circular RAM with positional insert/remove.
//
//  channel   dir  handshake            payload
//  in_cmd    in   valid/ready          func, position, item_value
//  out_rsp   out  valid/ready          status, value_valid, out_value, entry_count
//
// Commands (n = entries before the command, p = position): errors and unused
// codes go straight to the response; an insert at p < n shifts entries p to
// n - 1 one slot up, a remove at p shifts the entries after p one slot down.
// Shifting moves one entry per cycle through the RAM's single read and write
// ports; head/tail work is O(1) via a head pointer.
// Reset clears count and head pointer; RAM contents are left as they are.
// A finished response sits in the output register; the next command is taken
// while it waits, and only the following response stalls on out_rsp.ready.
`default_nettype none
module positional_list_engine #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  plr_cmd_if.sink     in_cmd,
  plr_rsp_if.source   out_rsp
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int VW   = VALUE_WIDTH;
  localparam int CMPW = (CW > plr_pkg::POS_W) ? CW : plr_pkg::POS_W;

  // logical index -> RAM address, wrapping around the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // control registers
  plr_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  plr_pkg::tag_t    tag_r, tag_nxt;
  logic             out_valid_r, out_valid_nxt;

  // per-command working registers
  logic [AW-1:0]    base_r, base_nxt;   // head at accept time (the new head for an insert at head)
  logic [AW-1:0]    idx_r, idx_nxt;     // next logical index to read
  logic [AW-1:0]    end_r, end_nxt;     // last index of a downward sweep
  logic [AW-1:0]    pos_r, pos_nxt;     // insert slot / stop of upward sweep
  logic [AW-1:0]    wb_r, wb_nxt;       // write-back address for moved entry
  logic             first_r, first_nxt;
  logic             ins_r, ins_nxt;
  logic [VW-1:0]    item_r, item_nxt;
  plr_pkg::status_t status_r, status_nxt;
  logic             vvalid_r, vvalid_nxt;
  logic [VW-1:0]    value_r, value_nxt;

  // output register
  plr_pkg::status_t            out_status_r, out_status_nxt;
  logic                        out_vvalid_r, out_vvalid_nxt;
  logic [plr_pkg::ITEM_W-1:0]  out_value_r, out_value_nxt;
  logic [plr_pkg::CNT_W-1:0]   out_count_r, out_count_nxt;

  // RAM port
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [VW-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [VW-1:0]  mem_rdata;

  // command decode
  logic             in_ready, acc;
  logic             full, empty, is_ins, is_rem, mid_shift, resp_load;
  logic [CMPW-1:0]  pos_ext, cnt_ext;
  logic [AW-1:0]    pos_a, cnt_a, cnt_m1;
  plr_pkg::status_t dec_status;

  assign in_ready  = (state_r == plr_pkg::S_IDLE);
  assign acc       = in_cmd.valid && in_ready;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_ext   = CMPW'(in_cmd.position);
  assign cnt_ext   = CMPW'(count_r);
  assign pos_a     = AW'(in_cmd.position);
  assign cnt_a     = AW'(count_r);
  assign cnt_m1    = AW'(count_r - CW'(1));
  assign resp_load = (state_r == plr_pkg::S_RESP) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    is_ins = in_cmd.func inside {plr_pkg::FN_INS_HEAD, plr_pkg::FN_INS_TAIL,
                                 plr_pkg::FN_INS_POS};
    is_rem = in_cmd.func inside {plr_pkg::FN_REM_HEAD, plr_pkg::FN_REM_TAIL,
                                 plr_pkg::FN_REM_POS, plr_pkg::FN_READ};
    mid_shift = (in_cmd.func == plr_pkg::FN_INS_POS) && (pos_ext < cnt_ext);
  end

  // status: empty beats bad position on removes, bad position beats full on inserts
  always_comb begin
    dec_status = plr_pkg::ST_OK;
    case (in_cmd.func)
      plr_pkg::FN_INS_HEAD, plr_pkg::FN_INS_TAIL: begin
        if (full) dec_status = plr_pkg::ST_FULL;
      end
      plr_pkg::FN_INS_POS: begin
        if (pos_ext > cnt_ext)  dec_status = plr_pkg::ST_BADPOS;
        else if (full)          dec_status = plr_pkg::ST_FULL;
      end
      plr_pkg::FN_REM_HEAD, plr_pkg::FN_REM_TAIL: begin
        if (empty) dec_status = plr_pkg::ST_EMPTY;
      end
      plr_pkg::FN_REM_POS, plr_pkg::FN_READ: begin
        if (empty)                   dec_status = plr_pkg::ST_EMPTY;
        else if (pos_ext >= cnt_ext) dec_status = plr_pkg::ST_BADPOS;
      end
      default: dec_status = plr_pkg::ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plr_pkg::S_IDLE: begin
        if (acc) begin
          if (dec_status != plr_pkg::ST_OK || !(is_ins || is_rem)) begin
            state_nxt = plr_pkg::S_RESP;
          end else if (is_ins) begin
            state_nxt = mid_shift ? plr_pkg::S_UP : plr_pkg::S_PUT;
          end else begin
            state_nxt = plr_pkg::S_DN;
          end
        end
      end
      plr_pkg::S_UP:   if (idx_r == pos_r) state_nxt = plr_pkg::S_WAIT;
      plr_pkg::S_DN:   if (idx_r == end_r) state_nxt = plr_pkg::S_WAIT;
      plr_pkg::S_WAIT: state_nxt = ins_r ? plr_pkg::S_PUT : plr_pkg::S_RESP;
      plr_pkg::S_PUT:  state_nxt = plr_pkg::S_RESP;
      plr_pkg::S_RESP: if (resp_load) state_nxt = plr_pkg::S_IDLE;
      default:         state_nxt = plr_pkg::S_IDLE;
    endcase
  end

  // datapath, RAM control and output register
  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    tag_nxt    = plr_pkg::TAG_NONE;
    base_nxt   = base_r;
    idx_nxt    = idx_r;
    end_nxt    = end_r;
    pos_nxt    = pos_r;
    wb_nxt     = wb_r;
    first_nxt  = first_r;
    ins_nxt    = ins_r;
    item_nxt   = item_r;
    status_nxt = status_r;
    vvalid_nxt = vvalid_r;
    value_nxt  = value_r;
    mem_we     = 1'b0;
    mem_waddr  = wb_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;

    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_vvalid_nxt = out_vvalid_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;

    // read data from the previous cycle: keep it or move it
    if (tag_r == plr_pkg::TAG_MOVE) begin
      mem_we = 1'b1;
    end else if (tag_r == plr_pkg::TAG_CAPTURE) begin
      value_nxt = mem_rdata;
    end

    case (state_r)
      plr_pkg::S_IDLE: begin
        if (acc) begin
          status_nxt = dec_status;
          ins_nxt    = is_ins;
          vvalid_nxt = 1'b0;
          value_nxt  = '0;
          first_nxt  = 1'b1;
          item_nxt   = VW'(in_cmd.item_value);
          base_nxt   = head_r;
          if (dec_status == plr_pkg::ST_OK && is_ins) begin
            count_nxt = count_r + CW'(1);
            case (in_cmd.func)
              plr_pkg::FN_INS_HEAD: begin
                head_nxt = phys(head_r, AW'(CAPACITY - 1));
                base_nxt = phys(head_r, AW'(CAPACITY - 1));
                pos_nxt  = '0;
              end
              plr_pkg::FN_INS_TAIL: pos_nxt = cnt_a;
              default: begin
                pos_nxt = pos_a;
                idx_nxt = cnt_m1;
              end
            endcase
          end else if (dec_status == plr_pkg::ST_OK && is_rem) begin
            vvalid_nxt = 1'b1;
            case (in_cmd.func)
              plr_pkg::FN_REM_HEAD: begin
                idx_nxt   = '0;
                end_nxt   = '0;
                head_nxt  = phys(head_r, AW'(1));
                count_nxt = count_r - CW'(1);
              end
              plr_pkg::FN_REM_TAIL: begin
                idx_nxt   = cnt_m1;
                end_nxt   = cnt_m1;
                count_nxt = count_r - CW'(1);
              end
              plr_pkg::FN_REM_POS: begin
                idx_nxt   = pos_a;
                end_nxt   = cnt_m1;
                count_nxt = count_r - CW'(1);
              end
              default: begin
                idx_nxt = pos_a;
                end_nxt = pos_a;
              end
            endcase
          end
        end
      end
      plr_pkg::S_UP: begin
        // walk down from the tail, each entry moves one slot up
        mem_raddr = phys(base_r, idx_r);
        tag_nxt   = plr_pkg::TAG_MOVE;
        wb_nxt    = phys(base_r, idx_r + AW'(1));
        if (idx_r != pos_r) idx_nxt = idx_r - AW'(1);
      end
      plr_pkg::S_DN: begin
        // first read is the removed/read entry, the rest move one slot down
        mem_raddr = phys(base_r, idx_r);
        tag_nxt   = first_r ? plr_pkg::TAG_CAPTURE : plr_pkg::TAG_MOVE;
        wb_nxt    = phys(base_r, idx_r - AW'(1));
        first_nxt = 1'b0;
        if (idx_r != end_r) idx_nxt = idx_r + AW'(1);
      end
      plr_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = phys(base_r, pos_r);
        mem_wdata = item_r;
      end
      plr_pkg::S_RESP: begin
        if (resp_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_vvalid_nxt = vvalid_r;
          out_value_nxt  = vvalid_r ? plr_pkg::ITEM_W'(value_r) : '0;
          out_count_nxt  = plr_pkg::CNT_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plr_pkg::S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tag_r       <= plr_pkg::TAG_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    pos_r        <= pos_nxt;
    wb_r         <= wb_nxt;
    first_r      <= first_nxt;
    ins_r        <= ins_nxt;
    item_r       <= item_nxt;
    status_r     <= status_nxt;
    vvalid_r     <= vvalid_nxt;
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_vvalid_r <= out_vvalid_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  plr_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_cmd.ready        = in_ready;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.value_valid = out_vvalid_r;
  assign out_rsp.out_value   = out_value_r;
  assign out_rsp.entry_count = out_count_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plr_pkg::S_IDLE || state_r == plr_pkg::S_PUT) |-> tag_r == plr_pkg::TAG_NONE)
    else $error("RAM read still in flight when the sweep is over");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_ins && dec_status == plr_pkg::ST_OK) |=> count_r == CW'($past(count_r) + CW'(1)))
    else $error("successful insert did not grow the list");

  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && dec_status == plr_pkg::ST_OK &&
     (in_cmd.func == plr_pkg::FN_REM_HEAD || in_cmd.func == plr_pkg::FN_REM_TAIL ||
      in_cmd.func == plr_pkg::FN_REM_POS))
    |=> count_r == CW'($past(count_r) - CW'(1)))
    else $error("successful remove did not shrink the list");

endmodule
`default_nettype wire

// ===== bench/positional_list_engine_test.sv =====
// Testbench: self-checking bench for the positional list engine.
`default_nettype none
module positional_list_engine_test;

  localparam int CAPACITY     = 1024;
  localparam int HALF_PERIOD  = 6;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the engine
  localparam int TAIL_CYCLES  = 64;    // quiet time after the last response
  localparam int ITEMS_PER_PHASE = 206;

  // func code 7 is unused by the engine: it must answer with a plain OK
  localparam logic [plr_pkg::FUNC_W-1:0] FN_NOP = 3'd7;

  typedef struct packed {
    plr_pkg::status_t             status;
    logic                         value_valid;
    logic [plr_pkg::ITEM_W-1:0]   value;
    logic [plr_pkg::CNT_W-1:0]    count;
  } rsp_t;

  // one directed step; want is only used where typed is set
  typedef struct packed {
    logic [plr_pkg::FUNC_W-1:0]   fn;
    logic [plr_pkg::POS_W-1:0]    pos;
    logic [plr_pkg::ITEM_W-1:0]   val;
    logic                         typed;
    rsp_t                         want;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;

  // Opening sequence from reset. Comments track the list contents, head first.
  script_row_t script [SCRIPT_LEN] = '{
    // empty list: removes and reads report empty, even at an absurd position
    '{plr_pkg::FN_REM_HEAD, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0}},
    '{plr_pkg::FN_REM_TAIL, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0}},
    '{plr_pkg::FN_REM_POS, 11'd2047, 32'h0, 1'b1,
      '{plr_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0}},
    '{plr_pkg::FN_READ, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0}},
    // insert past the count is a bad position
    '{plr_pkg::FN_INS_POS, 11'd1, 32'h12345678, 1'b1,
      '{plr_pkg::ST_BADPOS, 1'b0, 32'h0, 11'd0}},
    '{FN_NOP, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_OK, 1'b0, 32'h0, 11'd0}},
    // [F]
    '{plr_pkg::FN_INS_HEAD, 11'd0, 32'hffffffff, 1'b1,
      '{plr_pkg::ST_OK, 1'b0, 32'h0, 11'd1}},
    // [F,0]
    '{plr_pkg::FN_INS_TAIL, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_OK, 1'b0, 32'h0, 11'd2}},
    // insert at position == count appends: [F,0,A5]
    '{plr_pkg::FN_INS_POS, 11'd2, 32'ha5a5a5a5, 1'b1,
      '{plr_pkg::ST_OK, 1'b0, 32'h0, 11'd3}},
    // [F,5A,0,A5]
    '{plr_pkg::FN_INS_POS, 11'd1, 32'h5a5a5a5a, 1'b0, '0},
    '{plr_pkg::FN_INS_POS, 11'd2047, 32'hdeadbeef, 1'b1,
      '{plr_pkg::ST_BADPOS, 1'b0, 32'h0, 11'd4}},
    '{plr_pkg::FN_READ, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_OK, 1'b1, 32'hffffffff, 11'd4}},
    // read at count and far beyond
    '{plr_pkg::FN_READ, 11'd4, 32'h0, 1'b1,
      '{plr_pkg::ST_BADPOS, 1'b0, 32'h0, 11'd4}},
    '{plr_pkg::FN_READ, 11'd1024, 32'h0, 1'b1,
      '{plr_pkg::ST_BADPOS, 1'b0, 32'h0, 11'd4}},
    '{plr_pkg::FN_READ, 11'd3, 32'h0, 1'b0, '0},
    // [F,0,A5]
    '{plr_pkg::FN_REM_POS, 11'd1, 32'h0, 1'b0, '0},
    // [0,A5]
    '{plr_pkg::FN_REM_HEAD, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_OK, 1'b1, 32'hffffffff, 11'd2}},
    // [0]
    '{plr_pkg::FN_REM_TAIL, 11'd0, 32'h0, 1'b0, '0},
    '{plr_pkg::FN_REM_POS, 11'd5, 32'h0, 1'b1,
      '{plr_pkg::ST_BADPOS, 1'b0, 32'h0, 11'd1}},
    '{FN_NOP, 11'd2047, 32'hffffffff, 1'b1,
      '{plr_pkg::ST_OK, 1'b0, 32'h0, 11'd1}},
    // []
    '{plr_pkg::FN_REM_POS, 11'd0, 32'h0, 1'b0, '0},
    '{plr_pkg::FN_INS_TAIL, 11'd0, 32'h00000001, 1'b1,
      '{plr_pkg::ST_OK, 1'b0, 32'h0, 11'd1}},
    '{plr_pkg::FN_REM_HEAD, 11'd0, 32'h0, 1'b0, '0},
    // insert at position 0 of an empty list appends
    '{plr_pkg::FN_INS_POS, 11'd0, 32'h80000000, 1'b1,
      '{plr_pkg::ST_OK, 1'b0, 32'h0, 11'd1}},
    '{plr_pkg::FN_REM_POS, 11'd0, 32'h0, 1'b1,
      '{plr_pkg::ST_OK, 1'b1, 32'h80000000, 11'd0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  plr_cmd_if in_cmd();
  plr_rsp_if out_rsp();

  positional_list_engine #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (plr_pkg::ITEM_W)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_cmd),
    .out_rsp (out_rsp)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Mirror of the list contents, head at index 0
  logic [plr_pkg::ITEM_W-1:0] shadow_list [$];
  rsp_t                       pending_rsp [$];

  int mismatch_cnt  = 0;
  int rsp_seen      = 0;
  int send_idle_pct = 0;    // chance per cycle that the sender holds back
  int stall_pct     = 0;    // chance per cycle that the receiver holds back
  int list_ceiling  = 48;   // random mix keeps the list around this size
  int hold_req      = 0;    // bumped by the stimulus to request a long hold-off
  int hold_ack      = 0;
  int hold_left     = 0;

  // Apply one command to the mirror and return the response it must produce.
  function automatic rsp_t apply_to_shadow(logic [plr_pkg::FUNC_W-1:0] fn,
                                           logic [plr_pkg::POS_W-1:0] pos,
                                           logic [plr_pkg::ITEM_W-1:0] val);
    rsp_t r;
    int   n;
    int   p;
    r = '0;
    r.status = plr_pkg::ST_OK;
    n = shadow_list.size();
    case (fn)
      plr_pkg::FN_INS_HEAD, plr_pkg::FN_INS_TAIL, plr_pkg::FN_INS_POS: begin
        p = (fn == plr_pkg::FN_INS_HEAD) ? 0 : (fn == plr_pkg::FN_INS_TAIL) ? n : int'(pos);
        // bad position wins over full
        if (fn == plr_pkg::FN_INS_POS && p > n) r.status = plr_pkg::ST_BADPOS;
        else if (n >= CAPACITY) r.status = plr_pkg::ST_FULL;
        else shadow_list.insert(p, val);
      end
      plr_pkg::FN_REM_HEAD, plr_pkg::FN_REM_TAIL, plr_pkg::FN_REM_POS,
      plr_pkg::FN_READ: begin
        p = (fn == plr_pkg::FN_REM_HEAD) ? 0 :
            (fn == plr_pkg::FN_REM_TAIL) ? n - 1 : int'(pos);
        // empty wins over bad position
        if (n == 0) r.status = plr_pkg::ST_EMPTY;
        else if (p >= n) r.status = plr_pkg::ST_BADPOS;
        else begin
          r.value_valid = 1'b1;
          r.value = shadow_list[p];
          if (fn != plr_pkg::FN_READ) shadow_list.delete(p);
        end
      end
      default: ;
    endcase
    r.count = plr_pkg::CNT_W'(shadow_list.size());
    return r;
  endfunction

  task automatic flag_error(string what, logic [plr_pkg::ITEM_W-1:0] got,
                            logic [plr_pkg::ITEM_W-1:0] want);
    $display("rsp %0d: %s got %0h want %0h", rsp_seen, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one command; on the transfer, predict its response.
  task automatic send_cmd(input logic [plr_pkg::FUNC_W-1:0] fn,
                          input logic [plr_pkg::POS_W-1:0] pos,
                          input logic [plr_pkg::ITEM_W-1:0] val, input logic typed,
                          input rsp_t want);
    rsp_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_cmd.valid <= 1'b0;
      @(posedge clk);
    end
    in_cmd.valid      <= 1'b1;
    in_cmd.func       <= fn;
    in_cmd.position   <= pos;
    in_cmd.item_value <= val;
    do @(posedge clk); while (!in_cmd.ready);
    predicted = apply_to_shadow(fn, pos, val);
    pending_rsp.push_back(typed ? want : predicted);
  endtask

  // Sender goes quiet until every outstanding response is back.
  task automatic wait_drained();
    in_cmd.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // Mostly well-formed commands, with the list size steered toward list_ceiling.
  task automatic pick_cmd(output logic [plr_pkg::FUNC_W-1:0] fn,
                          output logic [plr_pkg::POS_W-1:0] pos,
                          output logic [plr_pkg::ITEM_W-1:0] val);
    int n;
    int grow_pct;
    int sel;
    n = shadow_list.size();
    grow_pct = (n < list_ceiling / 4) ? 70 : (n > list_ceiling) ? 25 : 50;
    if ($urandom_range(99) < 3) fn = FN_NOP;
    else if ($urandom_range(99) < grow_pct) begin
      case ($urandom_range(2))
        0:       fn = plr_pkg::FN_INS_HEAD;
        1:       fn = plr_pkg::FN_INS_TAIL;
        default: fn = plr_pkg::FN_INS_POS;
      endcase
    end else begin
      case ($urandom_range(3))
        0:       fn = plr_pkg::FN_REM_HEAD;
        1:       fn = plr_pkg::FN_REM_TAIL;
        2:       fn = plr_pkg::FN_REM_POS;
        default: fn = plr_pkg::FN_READ;
      endcase
    end
    // some wild positions, some right at the count, the rest in range
    sel = $urandom_range(99);
    if (sel < 8) pos = plr_pkg::POS_W'($urandom);
    else if (sel < 15) pos = plr_pkg::POS_W'(n);
    else if (fn == plr_pkg::FN_INS_POS) pos = plr_pkg::POS_W'($urandom_range(n));
    else pos = (n == 0) ? '0 : plr_pkg::POS_W'($urandom_range(n - 1));
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_rsp.ready <= 1'b0;
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Response checker: every transfer is matched against the oldest prediction
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        flag_error("response with nothing pending", out_rsp.out_value, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.status !== want.status)
          flag_error("status", plr_pkg::ITEM_W'(out_rsp.status),
                     plr_pkg::ITEM_W'(want.status));
        if (out_rsp.value_valid !== want.value_valid)
          flag_error("value_valid", plr_pkg::ITEM_W'(out_rsp.value_valid),
                     plr_pkg::ITEM_W'(want.value_valid));
        if (out_rsp.out_value !== want.value)
          flag_error("out_value", out_rsp.out_value, want.value);
        if (out_rsp.entry_count !== want.count)
          flag_error("entry_count", plr_pkg::ITEM_W'(out_rsp.entry_count),
                     plr_pkg::ITEM_W'(want.count));
      end
    end
  end

  initial begin : stimulus
    logic [plr_pkg::FUNC_W-1:0] fn;
    logic [plr_pkg::POS_W-1:0]  pos;
    logic [plr_pkg::ITEM_W-1:0] val;
    int                         phase_send [4];
    int                         phase_stall[4];
    int                         phase_ceil [4];

    phase_send  = '{0, 75, 0, 10};
    phase_stall = '{0, 0, 75, 10};
    phase_ceil  = '{48, 8, 96, 24};

    in_cmd.valid      <= 1'b0;
    in_cmd.func       <= FN_NOP;
    in_cmd.position   <= '0;
    in_cmd.item_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, no idling on either side
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_cmd(script[i].fn, script[i].pos, script[i].val, script[i].typed, script[i].want);

    // Random mix in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_send[ph];
      stall_pct     = phase_stall[ph];
      list_ceiling  = phase_ceil[ph];
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // receiver holds off while the sender keeps pushing: backpressure to input
        if (ph == 0 && k == 100) hold_req <= hold_req + 1;
        // sender pause until every response is home
        if (ph == 2 && k == 100) wait_drained();
        pick_cmd(fn, pos, val);
        send_cmd(fn, pos, val, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("positional_list_engine_test: clean");
    else
      $display("positional_list_engine_test: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("positional_list_engine_test: errors");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/plr_pkg.sv
rtl/plr_if.sv
rtl/plr_ram.sv
rtl/positional_list_engine.sv
bench/positional_list_engine_test.sv
